// ===== src/box_average_pyramid_downsample_defines.svh =====
// Assertion helpers for the block's RTL.
`ifndef BOX_AVERAGE_PYRAMID_DOWNSAMPLE_DEFINES_SVH
`define BOX_AVERAGE_PYRAMID_DOWNSAMPLE_DEFINES_SVH

// Invariant that holds at every edge out of reset.
`define BAPD_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define BAPD_CHECK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BAPD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bapd_pkg.sv =====
`default_nettype none

package bapd_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int PIX_W     = 16;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int POS_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SIZE_W    = 11;
  localparam int EXT_W     = SIZE_W + 1;
  localparam int SH_W      = 3;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int WORD_W    = 2 * PIX_W;

  // 9 taps of PIX_W bits
  localparam int SUM_W     = PIX_W + 4;
  localparam int RECIP_W   = 22;
  localparam int DIV_SHIFT = 23;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int PEND_W    = PTR_W + 1;
  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(OUT_DEPTH);

  localparam logic [SH_W-1:0]   SH_MIN   = SH_W'(1);
  localparam logic [SH_W-1:0]   SH_MAX   = SH_W'(5);
  localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(MAX_ROWS);

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_SHIFT = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;

  typedef enum logic [1:0] {
    DIV_NINE = 2'd0,
    DIV_SIX  = 2'd1,
    DIV_FOUR = 2'd2
  } div_t;

  typedef struct packed {
    logic hit;
    logic clip;
    logic last;
  } emit_t;

  // control of the item whose line-buffer read is in flight
  typedef struct packed {
    logic valid;
    logic emit;
    logic fwd;
    logic clip_x;
    logic clip_y;
    logic last;
  } s0_ctrl_t;

  typedef struct packed {
    logic valid;
    logic last;
    div_t div;
  } sum_ctrl_t;

  // Does line pos close the window of some destination index along an axis of
  // extent n? clip: window runs past the far edge, first tap dropped.
  function automatic emit_t emit_f(input logic [POS_W-1:0] pos,
                                   input logic [SIZE_W-1:0] n,
                                   input logic [SH_W-1:0] sh);
    logic [EXT_W-1:0] p, s, half, mask, cnt, da, db, ia, ib, ne;
    emit_t e;
    p    = EXT_W'(pos);
    ne   = EXT_W'(n);
    s    = EXT_W'(1) << sh;
    half = s >> 1;
    mask = s - EXT_W'(1);
    cnt  = ne >> sh;
    da   = p - half - EXT_W'(1);
    db   = p - half;
    ia   = da >> sh;
    ib   = db >> sh;
    priority if (p > half && (da & mask) == '0 && ia < cnt) begin
      e.hit  = 1'b1;
      e.clip = 1'b0;
      e.last = (ia + EXT_W'(1)) == cnt;
    end else if ((p + EXT_W'(1)) == ne && p >= half && (db & mask) == '0 && ib < cnt) begin
      e.hit  = 1'b1;
      e.clip = 1'b1;
      e.last = (ib + EXT_W'(1)) == cnt;
    end else begin
      e = '0;
    end
    return e;
  endfunction

  // ceil(2^DIV_SHIFT / n): exact quotient for every SUM_W-bit dividend
  function automatic logic [RECIP_W-1:0] recip_f(input div_t d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      DIV_NINE: r = RECIP_W'(932068);
      DIV_SIX:  r = RECIP_W'(1398102);
      DIV_FOUR: r = RECIP_W'(2097152);
      default:  r = RECIP_W'(932068);
    endcase
    return r;
  endfunction

  // n/2 for round-half-up
  function automatic logic [SUM_W-1:0] round_f(input div_t d);
    logic [SUM_W-1:0] r;
    unique case (d)
      DIV_NINE: r = SUM_W'(4);
      DIV_SIX:  r = SUM_W'(3);
      DIV_FOUR: r = SUM_W'(2);
      default:  r = SUM_W'(4);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/bapd_in_if.sv =====
`default_nettype none

interface bapd_in_if;
  logic                       valid;
  logic                       ready;
  logic [bapd_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== src/bapd_out_if.sv =====
`default_nettype none

interface bapd_out_if;
  logic                       valid;
  logic                       ready;
  logic [bapd_pkg::PIX_W-1:0] pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== src/bapd_line_ram.sv =====
`default_nettype none

module bapd_line_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/bapd_window_sum.sv =====
`default_nettype none

module bapd_window_sum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bapd_pkg::s0_ctrl_t          s0,
  input  wire logic [bapd_pkg::PIX_W-1:0]  pixel,
  input  wire logic [bapd_pkg::WORD_W-1:0] rd_data,
  output      logic [bapd_pkg::WORD_W-1:0] wr_data,
  output      bapd_pkg::sum_ctrl_t         sum_ctl_r,
  output      logic [bapd_pkg::SUM_W-1:0]  sum_r
);

  logic [bapd_pkg::WORD_W-1:0] fwd_word_r;
  logic [bapd_pkg::WORD_W-1:0] word;
  logic [bapd_pkg::PIX_W-1:0]  col [3];
  logic [bapd_pkg::PIX_W-1:0]  win_r [6];
  logic [bapd_pkg::SUM_W-1:0]  tap [9];
  logic [bapd_pkg::SUM_W-1:0]  sum_nxt;
  bapd_pkg::div_t              div_nxt;

  // word layout: older row in the upper half, newer row in the lower
  assign word    = s0.fwd ? fwd_word_r : rd_data;
  assign col[0]  = word[bapd_pkg::PIX_W +: bapd_pkg::PIX_W];
  assign col[1]  = word[0 +: bapd_pkg::PIX_W];
  assign col[2]  = pixel;
  assign wr_data = {col[1], pixel};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if ((s0.clip_x && j == 0) || (s0.clip_y && i == 0)) begin
          tap[j*3+i] = '0;
        end else if (j < 2) begin
          tap[j*3+i] = bapd_pkg::SUM_W'(win_r[j*3+i]);
        end else begin
          tap[j*3+i] = bapd_pkg::SUM_W'(col[i]);
        end
      end
    end
    sum_nxt = (tap[0] + tap[1] + tap[2]) + (tap[3] + tap[4] + tap[5]) +
              (tap[6] + tap[7] + tap[8]);
  end

  always_comb begin
    priority if (s0.clip_x && s0.clip_y) begin
      div_nxt = bapd_pkg::DIV_FOUR;
    end else if (s0.clip_x || s0.clip_y) begin
      div_nxt = bapd_pkg::DIV_SIX;
    end else begin
      div_nxt = bapd_pkg::DIV_NINE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
      sum_ctl_r.valid <= 1'b0;
    end else begin
      sum_ctl_r.valid <= s0.valid && s0.emit;
      if (s0.valid) begin
        sum_ctl_r.last <= s0.last;
        sum_ctl_r.div  <= div_nxt;
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= col[0];
        win_r[4] <= col[1];
        win_r[5] <= col[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0.valid) begin
      fwd_word_r <= wr_data;
      sum_r      <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bapd_avg_div.sv =====
`default_nettype none

module bapd_avg_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bapd_pkg::sum_ctrl_t        sum_ctl,
  input  wire logic [bapd_pkg::SUM_W-1:0] sum,
  output      logic                       push,
  output      logic [bapd_pkg::PIX_W-1:0] avg,
  output      logic                       last
);

  logic [bapd_pkg::SUM_W-1:0]  dividend;
  logic [bapd_pkg::PROD_W-1:0] prod_r;
  logic                        valid_r;
  logic                        last_r;

  // (sum + n/2) * ceil(2^k/n) >> k
  assign dividend = sum + bapd_pkg::round_f(sum_ctl.div);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sum_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ctl.valid) begin
      prod_r <= bapd_pkg::PROD_W'(dividend) *
                bapd_pkg::PROD_W'(bapd_pkg::recip_f(sum_ctl.div));
      last_r <= sum_ctl.last;
    end
  end

  assign push = valid_r;
  assign avg  = prod_r[bapd_pkg::DIV_SHIFT +: bapd_pkg::PIX_W];
  assign last = last_r;

endmodule

`default_nettype wire

// ===== src/bapd_out_fifo.sv =====
`default_nettype none

module bapd_out_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [bapd_pkg::PIX_W-1:0] push_pixel,
  input  wire logic                       push_last,
  input  wire logic                       pop,
  output      logic                       not_empty,
  output      logic [bapd_pkg::PIX_W-1:0] head_pixel,
  output      logic                       head_last
);

  logic [bapd_pkg::PIX_W:0]    slot_r [bapd_pkg::OUT_DEPTH];
  logic [bapd_pkg::PTR_W-1:0]  wr_ptr_r;
  logic [bapd_pkg::PTR_W-1:0]  rd_ptr_r;
  logic [bapd_pkg::PEND_W-1:0] count_r;
  logic                        do_pop;

  // caller never pushes into a full queue (credit counted upstream)
  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + bapd_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bapd_pkg::PTR_W'(1);
      end
      count_r <= count_r + bapd_pkg::PEND_W'(push) - bapd_pkg::PEND_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= {push_last, push_pixel};
    end
  end

  assign not_empty  = count_r != '0;
  assign head_pixel = slot_r[rd_ptr_r][bapd_pkg::PIX_W-1:0];
  assign head_last  = slot_r[rd_ptr_r][bapd_pkg::PIX_W];

endmodule

`default_nettype wire

// ===== src/box_average_pyramid_downsample.sv =====
// Box-average pyramid reduction: one pass over one source level.
// in_chan takes source pixels (unsigned 8.8) in raster order, one per
// transaction. out_chan gives one averaged destination pixel per 3x3
// window, in raster order, with frame_last on the final one of the image.
// The APB port sets subsampling_log2 (0x0), source_cols (0x4) and
// source_rows (0x8), clamped; a write to any of them restarts the frame.
// Write only when the block is idle.
// Throughput: one pixel per clock unless stalled. Each pixel makes one
// read and one write of the packed two-row line memory (read at accept,
// write-back the cycle after, forwarded if a column comes back at once).
// Path: after its last source pixel is accepted, a result is held in
// s0_r, then sum_r, then the divider product, then the output queue,
// and it can complete its transaction on the following edge.
// Stall: an 8-entry output queue with a credit count decouples the sides;
// in_chan.ready drops only when eight results are queued or in flight.
// Reset (synchronous, rst_n low): config back to 1/640/480, counters,
// window and queue cleared; the line memory is not cleared, so a whole
// frame must stream before its rows are relied upon.
`default_nettype none
`include "box_average_pyramid_downsample_defines.svh"

module box_average_pyramid_downsample (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bapd_in_if.sink                          in_chan,
  bapd_out_if.source                       out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bapd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bapd_pkg::DATA_W-1:0] pwdata,
  output      logic [bapd_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);

  // configuration
  logic [bapd_pkg::SH_W-1:0]   sh_r;
  logic [bapd_pkg::SIZE_W-1:0] cols_r;
  logic [bapd_pkg::SIZE_W-1:0] rows_r;
  logic [1:0]                  reg_idx;
  logic                        cfg_wr;
  logic                        restart;
  logic [bapd_pkg::SH_W-1:0]   sh_in;
  logic [bapd_pkg::SIZE_W-1:0] size_in;
  logic [bapd_pkg::SIZE_W-1:0] cols_in;
  logic [bapd_pkg::SIZE_W-1:0] rows_in;

  // raster position of the next source pixel
  logic [bapd_pkg::COL_W-1:0]  c_r;
  logic [bapd_pkg::ROW_W-1:0]  r_r;
  logic                        row_end;
  logic                        frame_end;

  // accept stage
  logic                        in_acc;
  logic                        out_acc;
  bapd_pkg::emit_t             ex;
  bapd_pkg::emit_t             ey;
  bapd_pkg::s0_ctrl_t          s0_r;
  logic [bapd_pkg::PIX_W-1:0]  pixel0_r;
  logic [bapd_pkg::COL_W-1:0]  c0_r;
  logic [bapd_pkg::PEND_W-1:0] pending_r;

  logic [bapd_pkg::WORD_W-1:0] rd_data;
  logic [bapd_pkg::WORD_W-1:0] wr_data;
  bapd_pkg::sum_ctrl_t         sum_ctl;
  logic [bapd_pkg::SUM_W-1:0]  sum;
  logic                        push;
  logic [bapd_pkg::PIX_W-1:0]  avg;
  logic                        avg_last;

  //--------------------------------------------------------------------
  // APB registers
  //--------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (reg_idx == bapd_pkg::REG_SHIFT ||
                              reg_idx == bapd_pkg::REG_COLS ||
                              reg_idx == bapd_pkg::REG_ROWS);

  always_comb begin
    sh_in   = pwdata[bapd_pkg::SH_W-1:0];
    size_in = pwdata[bapd_pkg::SIZE_W-1:0];
    if (sh_in < bapd_pkg::SH_MIN) begin
      sh_in = bapd_pkg::SH_MIN;
    end else if (sh_in > bapd_pkg::SH_MAX) begin
      sh_in = bapd_pkg::SH_MAX;
    end
    cols_in = size_in;
    rows_in = size_in;
    if (size_in == '0) begin
      cols_in = bapd_pkg::SIZE_W'(1);
      rows_in = bapd_pkg::SIZE_W'(1);
    end else begin
      if (size_in > bapd_pkg::COLS_MAX) cols_in = bapd_pkg::COLS_MAX;
      if (size_in > bapd_pkg::ROWS_MAX) rows_in = bapd_pkg::ROWS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r   <= bapd_pkg::SH_W'(1);
      cols_r <= bapd_pkg::SIZE_W'(640);
      rows_r <= bapd_pkg::SIZE_W'(480);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bapd_pkg::REG_SHIFT: sh_r   <= sh_in;
        bapd_pkg::REG_COLS:  cols_r <= cols_in;
        bapd_pkg::REG_ROWS:  rows_r <= rows_in;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bapd_pkg::REG_SHIFT: prdata = bapd_pkg::DATA_W'(sh_r);
      bapd_pkg::REG_COLS:  prdata = bapd_pkg::DATA_W'(cols_r);
      bapd_pkg::REG_ROWS:  prdata = bapd_pkg::DATA_W'(rows_r);
      default:             prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------
  // Input side: position counters, window decision, credit
  //--------------------------------------------------------------------
  // pending_r counts results accepted-for but not yet taken downstream
  assign in_chan.ready = pending_r < bapd_pkg::PEND_MAX;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = out_chan.valid && out_chan.ready;

  assign ex = bapd_pkg::emit_f(bapd_pkg::POS_W'(c_r), cols_r, sh_r);
  assign ey = bapd_pkg::emit_f(bapd_pkg::POS_W'(r_r), rows_r, sh_r);

  assign row_end   = (bapd_pkg::SIZE_W'(c_r) + bapd_pkg::SIZE_W'(1)) >= cols_r;
  assign frame_end = (bapd_pkg::SIZE_W'(r_r) + bapd_pkg::SIZE_W'(1)) >= rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r       <= '0;
      r_r       <= '0;
      s0_r      <= '0;
      pending_r <= '0;
    end else begin
      if (restart) begin
        c_r <= '0;
        r_r <= '0;
      end else if (in_acc) begin
        if (row_end) begin
          c_r <= '0;
          r_r <= frame_end ? '0 : r_r + bapd_pkg::ROW_W'(1);
        end else begin
          c_r <= c_r + bapd_pkg::COL_W'(1);
        end
      end
      s0_r.valid <= in_acc;
      if (in_acc) begin
        s0_r.emit   <= ex.hit && ey.hit;
        // back-to-back accept on one column: memory read misses last write
        s0_r.fwd    <= s0_r.valid && (c_r == c0_r);
        s0_r.clip_x <= ex.clip;
        s0_r.clip_y <= ey.clip;
        s0_r.last   <= ex.last && ey.last;
      end
      pending_r <= pending_r + bapd_pkg::PEND_W'(in_acc && ex.hit && ey.hit)
                             - bapd_pkg::PEND_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pixel0_r <= in_chan.pixel_in;
      c0_r     <= c_r;
    end
  end

  //--------------------------------------------------------------------
  // Line memory: {row r-2, row r-1} per column, read at accept,
  // written back the cycle after
  //--------------------------------------------------------------------
  bapd_line_ram #(
    .WIDTH (bapd_pkg::WORD_W),
    .DEPTH (bapd_pkg::MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s0_r.valid),
    .wr_addr (c0_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (c_r),
    .rd_data (rd_data)
  );

  bapd_window_sum u_window_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .s0        (s0_r),
    .pixel     (pixel0_r),
    .rd_data   (rd_data),
    .wr_data   (wr_data),
    .sum_ctl_r (sum_ctl),
    .sum_r     (sum)
  );

  bapd_avg_div u_avg_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_ctl (sum_ctl),
    .sum     (sum),
    .push    (push),
    .avg     (avg),
    .last    (avg_last)
  );

  bapd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pixel (avg),
    .push_last  (avg_last),
    .pop        (out_chan.ready),
    .not_empty  (out_chan.valid),
    .head_pixel (out_chan.pixel_out),
    .head_last  (out_chan.frame_last)
  );

  //--------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------
  `BAPD_CHECK(a_credit_cap, pending_r <= bapd_pkg::PEND_MAX, "credit count above queue depth")
  `BAPD_CHECK_IMPL(a_out_has_credit, out_chan.valid, pending_r != '0, "result without credit")
  `BAPD_CHECK_NEXT(a_emit_reaches_sum, s0_r.valid && s0_r.emit, sum_ctl.valid, "window result lost")

endmodule

`default_nettype wire

// ===== sim/box_average_pyramid_downsample_tb.sv =====
module box_average_pyramid_downsample_tb;
  import bapd_pkg::*;

  // Run shape
  localparam int HOLD_CYCLES     = 300;   // long output hold-off, fills the result queue
  localparam int SETTLE_CYCLES   = 8;     // pipeline drain before a register write
  localparam int TAIL_CYCLES     = 8;     // quiet time after the last average
  localparam int WATCHDOG_CYCLES = 2000;  // cycles with no transaction at all
  localparam int RANDOM_PIXELS   = 290;

  // 4x4 frame at factor 2: one average of each divisor (9, 6, 6, 4),
  // with rail, near-rail and mid-scale values among the windows.
  localparam logic [PIX_W-1:0] CORNER_FRAME [16] = '{
    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
    16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0003,
    16'h0000, 16'h8000, 16'h7FFF, 16'h0001
  };

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_last;
  } average_t;

  // Tracks the block's line buffers, window and raster position, predicts
  // each destination pixel and checks the averages that come out.
  class box_average_predictor;
    int unsigned      shift_log2;
    int unsigned      cols;
    int unsigned      rows;
    logic [PIX_W-1:0] line_older [MAX_COLS];
    logic [PIX_W-1:0] line_newer [MAX_COLS];
    logic [PIX_W-1:0] window [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    average_t         expected_averages [$];
    int unsigned      pixels_seen;
    int unsigned      averages_predicted;
    int unsigned      averages_checked;
    int unsigned      reg_writes;
    int unsigned      mismatches;

    function new();
      shift_log2 = 1;
      cols       = 640;
      rows       = 480;
      foreach (line_older[i]) begin
        line_older[i] = '0;
        line_newer[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_pos            = 0;
      row_pos            = 0;
      pixels_seen        = 0;
      averages_predicted = 0;
      averages_checked   = 0;
      reg_writes         = 0;
      mismatches         = 0;
    endfunction

    // Register write: values are clamped, and a write to a known register restarts the frame.
    function void set_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      int unsigned v;
      reg_writes++;
      case (idx)
        REG_SHIFT: begin
          v = value[2:0];
          if (v < 1) v = 1;
          if (v > 5) v = 5;
          shift_log2 = v;
        end
        REG_COLS: begin
          v = value[10:0];
          if (v < 1) v = 1;
          if (v > MAX_COLS) v = MAX_COLS;
          cols = v;
        end
        REG_ROWS: begin
          v = value[10:0];
          if (v < 1) v = 1;
          if (v > MAX_ROWS) v = MAX_ROWS;
          rows = v;
        end
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    // Does line pos complete the window of a destination index along an axis
    // of extent n? clip: the window hangs over the far edge.
    function bit closes_window(input int unsigned pos, input int unsigned n,
                               input int unsigned sh, output int unsigned idx,
                               output bit clip);
      int unsigned s, half, cnt;
      s    = 1 << sh;
      half = s >> 1;
      cnt  = n >> sh;
      idx  = 0;
      clip = 1'b0;
      if (pos >= half + 1 && ((pos - half - 1) & (s - 1)) == 0 &&
          ((pos - half - 1) >> sh) < cnt) begin
        idx = (pos - half - 1) >> sh;
        return 1'b1;
      end
      if (pos + 1 == n && pos >= half && ((pos - half) & (s - 1)) == 0 &&
          ((pos - half) >> sh) < cnt) begin
        idx  = (pos - half) >> sh;
        clip = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function int unsigned frame_pixels_left();
      return cols * rows - (row_pos * cols + col_pos);
    endfunction

    function void take_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      c, dx, dy, sum, taps, i0, j0;
      bit               clip_x, clip_y;
      logic [PIX_W-1:0] column [3];
      average_t         avg;
      pixels_seen++;
      c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
      column[0] = line_older[c];
      column[1] = line_newer[c];
      column[2] = pix;
      if (closes_window(row_pos, rows, shift_log2, dy, clip_y) &&
          closes_window(c, cols, shift_log2, dx, clip_x)) begin
        sum  = 0;
        taps = 0;
        i0   = clip_y;
        j0   = clip_x;
        for (int j = j0; j < 3; j++) begin
          for (int i = i0; i < 3; i++) begin
            sum += (j < 2) ? window[j * 3 + i] : column[i];
            taps++;
          end
        end
        avg.pixel      = PIX_W'((sum + taps / 2) / taps);
        avg.frame_last = (dy + 1 == (rows >> shift_log2)) &&
                         (dx + 1 == (cols >> shift_log2));
        expected_averages.push_back(avg);
        averages_predicted++;
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = column[0];
      window[4] = column[1];
      window[5] = column[2];
      line_older[c] = column[1];
      line_newer[c] = pix;
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_average(input logic [PIX_W-1:0] pix, input logic last);
      average_t want;
      if (expected_averages.size() == 0) begin
        $error("unexpected average: pixel_out=%h frame_last=%b", pix, last);
        mismatches++;
        return;
      end
      want = expected_averages.pop_front();
      averages_checked++;
      if (pix !== want.pixel) begin
        $error("pixel_out: expected %h, got %h", want.pixel, pix);
        mismatches++;
      end
      if (last !== want.frame_last) begin
        $error("frame_last: expected %b, got %b", want.frame_last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              hold_request = 1'b0;  // asks the result sink for a long hold-off
  int unsigned       quiet_cycles = 0;

  box_average_predictor predictor = new();

  bapd_in_if  in_if ();
  bapd_out_if out_if ();

  box_average_pyramid_downsample dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rails and mid-scale values show up often; the rest is uniform.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(16'h7FF0, 16'h8010));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    predictor.set_reg(idx, value);
  endtask

  // Valid stays high between back-to-back pixels; it only drops for a gap.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input int unsigned gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.pixel_in <= pix;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predictor.take_pixel(pix);
  endtask

  task automatic stream_pixels(input int unsigned count, input bit eager);
    repeat (count) send_pixel(pick_pixel(), eager ? 0 : pick_gap());
  endtask

  // Block is idle once every average is out and the pipeline has drained
  // pixels that make no result.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (predictor.expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register value with random bits above the field, so every pwdata bit toggles.
  function automatic logic [DATA_W-1:0] field_value(input int unsigned v,
                                                     input int unsigned bits);
    logic [DATA_W-1:0] w;
    w = $urandom;
    for (int b = 0; b < bits; b++) w[b] = v[b];
    return w;
  endfunction

  // Watchdog: ends the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL box_average_pyramid_downsample");
      $finish;
    end
  end

  // Result sink: random stalls, eager stretches, and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left, eager_left, hold_left;
    logic        take;
    stall_left = 0;
    eager_left = 0;
    hold_left  = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else if (eager_left != 0) begin
        eager_left--;
        take = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
        case ($urandom_range(0, 19))
          0:          eager_left = $urandom_range(40, 160);
          1, 2, 3, 4: stall_left = pick_gap();
          default:    ;
        endcase
      end
      out_if.ready <= take;
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        predictor.check_average(out_if.pixel_out, out_if.frame_last);
    end
  end

  initial begin : stimulus
    int unsigned       random_start, frame, count, budget;
    bit                eager;
    logic [DATA_W-1:0] w;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.pixel_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 4x4 at factor 2 (log2 written as 0, clamps to 1) gives full,
    // column-clipped, row-clipped and corner windows, last one flagged.
    write_reg(REG_SHIFT, 32'd0);
    write_reg(REG_COLS, 32'd4);
    write_reg(REG_ROWS, 32'd4);
    foreach (CORNER_FRAME[i]) send_pixel(CORNER_FRAME[i], i % 3);
    // Image smaller than the factor: log2 7 clamps to 5, width 0 to 1.
    // Three pixels make a whole frame, no average, counters wrap.
    settle();
    write_reg(REG_SHIFT, 32'd7);
    write_reg(REG_COLS, 32'd0);
    write_reg(REG_ROWS, 32'd3);
    repeat (3) send_pixel(pick_pixel(), pick_gap());

    // Widest line: 2047 clamps to 1024, two rows, factor 2. Only the start
    // of the first row is streamed, so no window closes.
    settle();
    write_reg(REG_SHIFT, 32'd1);
    write_reg(REG_COLS, 32'd2047);
    write_reg(REG_ROWS, 32'd2);
    stream_pixels(40, 1'b0);

    // Tallest image (clamped from 1500), two columns; only the top part of
    // the frame is streamed.
    settle();
    write_reg(REG_COLS, 32'd2);
    write_reg(REG_ROWS, 32'd1500);
    stream_pixels(40, 1'b0);

    // Back pressure: dense 4x4 frames while the sink holds off, so the
    // output queue fills and in_chan.ready drops.
    settle();
    write_reg(REG_SHIFT, 32'd1);
    write_reg(REG_COLS, 32'd4);
    write_reg(REG_ROWS, 32'd4);
    hold_request = 1'b1;
    stream_pixels(64, 1'b1);

    // Random phases: mostly whole frames, some cut short, random settings.
    random_start = predictor.pixels_seen;
    while (predictor.pixels_seen - random_start < RANDOM_PIXELS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1)) begin
          w = field_value(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                          $urandom_range(1, 3), 3);
          write_reg(REG_SHIFT, w);
        end
        if ($urandom_range(0, 1)) begin
          w = field_value(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24), 11);
          write_reg(REG_COLS, w);
        end
        if ($urandom_range(0, 1)) begin
          w = field_value(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12), 11);
          write_reg(REG_ROWS, w);
        end
      end
      frame = predictor.cols * predictor.rows;
      if ($urandom_range(0, 3) != 0)
        count = predictor.frame_pixels_left() + frame * $urandom_range(0, 2);
      else
        count = $urandom_range(1, frame);
      budget = RANDOM_PIXELS - (predictor.pixels_seen - random_start);
      if (count > budget) count = budget;
      eager = ($urandom_range(0, 3) == 0);
      stream_pixels(count, eager);
    end

    in_if.valid <= 1'b0;
    while (predictor.expected_averages.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d source pixels streamed, %0d averages checked, %0d register writes",
             predictor.pixels_seen, predictor.averages_checked, predictor.reg_writes);
    $display("factors 2 to 32, sizes 1 to 1024 with clamping, clipped windows, %s",
             "partial frames, a long output hold-off");
    if (predictor.mismatches == 0) begin
      $display("PASS box_average_pyramid_downsample");
    end else begin
      $display("%0d mismatches", predictor.mismatches);
      $display("FAIL box_average_pyramid_downsample");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bapd_pkg.sv
src/bapd_in_if.sv
src/bapd_out_if.sv
src/bapd_line_ram.sv
src/bapd_window_sum.sv
src/bapd_avg_div.sv
src/bapd_out_fifo.sv
src/box_average_pyramid_downsample.sv
sim/box_average_pyramid_downsample_tb.sv
